### rtl/fcmc_pkg.sv
`timescale 1ns / 1ps

package fcmc_pkg;

  // Cache geometry
  localparam int MAX_ENTRIES = 128;
  localparam int KEY_BITS    = 16;
  localparam int LANES       = 8;                    // keys compared per memory row
  localparam int ROWS        = MAX_ENTRIES / LANES;
  localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
  localparam int LANE_BITS   = $clog2(LANES);
  localparam int ROW_BITS    = IDX_BITS - LANE_BITS;

  // Capacity register and miss counter
  localparam int CAP_BITS = 8;
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(MAX_ENTRIES);
  localparam int CNT_BITS = 32;

  // Lookup queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_BITS  = $clog2(QUEUE_DEPTH);

  // Stream payload widths (padded to whole bytes)
  localparam int IN_DATA_BITS  = 16;
  localparam int OUT_DATA_BITS = 40;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
  } fcmc_item_t;

  typedef struct packed {
    logic                hit;
    logic [CNT_BITS-1:0] miss_total;
  } fcmc_result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } fcmc_state_t;

endpackage

### rtl/fcmc_front.sv
`timescale 1ns / 1ps

module fcmc_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fcmc_pkg::IN_DATA_BITS-1:0] in_tdata,   // [15:0] key
  input  logic                             q_pop,
  output fcmc_pkg::fcmc_item_t             q_head
);
  import fcmc_pkg::*;

  logic [KEY_BITS-1:0]   slot_r [QUEUE_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_r;
  logic [Q_PTR_BITS-1:0] rd_ptr_r;
  logic [Q_PTR_BITS:0]   count_r;
  logic                  push;
  logic                  pop;

  assign in_tready = (count_r != (Q_PTR_BITS+1)'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && (count_r != '0);

  assign q_head.valid = (count_r != '0);
  assign q_head.key   = slot_r[rd_ptr_r];

  // Key storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_tdata[KEY_BITS-1:0];
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/fcmc_back.sv
`timescale 1ns / 1ps

module fcmc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fcmc_pkg::CAP_BITS-1:0] cfg_data,
  input  fcmc_pkg::fcmc_item_t          q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fcmc_pkg::fcmc_result_t        out_result
);
  import fcmc_pkg::*;

  // Key store: one row holds LANES keys, read a row per cycle
  logic [KEY_BITS-1:0] key_mem [ROWS][LANES];
  logic [KEY_BITS-1:0] rd_row_r [LANES];

  logic [MAX_ENTRIES-1:0] valid_r;
  logic [CAP_BITS-1:0]    cap_r;
  logic [IDX_BITS-1:0]    ptr_r;
  logic [CNT_BITS-1:0]    miss_cnt_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [ROW_BITS-1:0]    row_r;
  logic [ROW_BITS-1:0]    pend_row_r;
  logic                   pend_r;
  logic                   hit_r;
  logic                   out_valid_r;
  fcmc_result_t           out_result_r;
  fcmc_state_t            state_r;
  fcmc_state_t            state_nxt;

  logic [CAP_BITS-1:0] cap_eff;
  logic [CAP_BITS-1:0] cap_m1;
  logic [ROW_BITS-1:0] last_row;
  logic                row_hit;
  logic [IDX_BITS-1:0] ins_ptr;
  logic [CAP_BITS-1:0] ptr_inc;
  logic [IDX_BITS-1:0] ptr_nxt;
  logic [CNT_BITS-1:0] miss_cnt_nxt;
  logic                out_free;
  logic                start;
  logic                rd_en;
  logic                done_fire;

  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_free   = !out_valid_r || out_ready;

  // Capacity in use: zero acts as one, large values clip to the entry count
  always_comb begin
    cap_eff = cap_r;
    if (cap_r == '0) begin
      cap_eff = CAP_BITS'(1);
    end else if (cap_r > CAP_BITS'(MAX_ENTRIES)) begin
      cap_eff = CAP_BITS'(MAX_ENTRIES);
    end
  end

  assign cap_m1   = cap_eff - 1'b1;
  assign last_row = cap_m1[IDX_BITS-1:LANE_BITS];

  // Compare the row read last cycle against the key
  always_comb begin
    logic [IDX_BITS-1:0] idx;
    row_hit = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      idx = {pend_row_r, LANE_BITS'(l)};
      if (valid_r[idx] && (rd_row_r[l] == key_r) && (CAP_BITS'(idx) < cap_eff)) begin
        row_hit = 1'b1;
      end
    end
  end

  // Insert slot and pointer advance on a miss
  assign ins_ptr = (CAP_BITS'(ptr_r) >= cap_eff) ? '0 : ptr_r;
  assign ptr_inc = CAP_BITS'(ins_ptr) + 1'b1;
  assign ptr_nxt = (ptr_inc >= cap_eff) ? '0 : ptr_inc[IDX_BITS-1:0];
  assign miss_cnt_nxt = (miss_cnt_r == '1) ? miss_cnt_r : miss_cnt_r + 1'b1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_head.valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (row_r == last_row) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    start     = 1'b0;
    rd_en     = 1'b0;
    done_fire = 1'b0;
    unique case (state_r)
      ST_IDLE:  start     = q_head.valid;
      ST_SCAN:  rd_en     = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  done_fire = out_free;
      default:  ;
    endcase
  end

  assign q_pop = start;

  // Key memory: row read, single key write on a miss
  always_ff @(posedge clk) begin
    if (rd_en) begin
      for (int l = 0; l < LANES; l++) begin
        rd_row_r[l] <= key_mem[row_r][l];
      end
    end
    if (done_fire && !hit_r) begin
      key_mem[ins_ptr[IDX_BITS-1:LANE_BITS]][ins_ptr[LANE_BITS-1:0]] <= key_r;
    end
  end

  // Item payload and scan bookkeeping
  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= q_head.key;
    end
    if (rd_en) begin
      pend_row_r <= row_r;
    end
    if (done_fire) begin
      out_result_r.hit        <= hit_r;
      out_result_r.miss_total <= hit_r ? miss_cnt_r : miss_cnt_nxt;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      valid_r     <= '0;
      ptr_r       <= '0;
      miss_cnt_r  <= '0;
      row_r       <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= rd_en;
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (start) begin
        row_r <= '0;
        hit_r <= 1'b0;
      end else begin
        if (rd_en) begin
          row_r <= row_r + 1'b1;
        end
        if (pend_r && row_hit) begin
          hit_r <= 1'b1;
        end
      end
      if (done_fire && !hit_r) begin
        valid_r[ins_ptr] <= 1'b1;
        ptr_r            <= ptr_nxt;
        miss_cnt_r       <= miss_cnt_nxt;
      end
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### rtl/fifo_cache_miss_counter.sv
`timescale 1ns / 1ps
// Channel   Ports                              Beat contents
// in_       in_tvalid in_tready in_tdata       [15:0] key
// out_      out_tvalid out_tready out_tdata    [0] hit, [32:1] miss_total, rest zero
// cfg_      cfg_valid cfg_ready cfg_data       [7:0] capacity
//
// A lookup pops the key, then reads the key store one row of 8 keys per cycle up to
// the row of the last slot of cap, cap being the capacity clipped to 1..128, and
// compares all 8 at once; a drain step and an update step follow.
// Reset is synchronous, active low: valid bits, pointer and miss count clear,
// capacity returns to 128. A two-beat queue keeps taking keys while a result
// waits on out_tready; the output register holds until it is taken.

module fifo_cache_miss_counter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fcmc_pkg::IN_DATA_BITS-1:0]  in_tdata,   // [15:0] key
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fcmc_pkg::OUT_DATA_BITS-1:0] out_tdata,  // [0] hit, [32:1] miss_total
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fcmc_pkg::CAP_BITS-1:0]      cfg_data    // [7:0] capacity
);
  import fcmc_pkg::*;

  fcmc_item_t   q_head;
  logic         q_pop;
  fcmc_result_t result;

  fcmc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_pop     (q_pop),
    .q_head    (q_head)
  );

  fcmc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result)
  );

  // Pack result fields, hit in the lowest bit
  assign out_tdata = OUT_DATA_BITS'({result.miss_total, result.hit});

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fcmc_pkg::*;

  localparam int RANDOM_ITEMS   = 700;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;

  // Predicts hit and miss count for every accepted key and checks the result beats
  class lookup_board;
    logic [KEY_BITS-1:0] slot_key [MAX_ENTRIES];
    bit                  slot_valid [MAX_ENTRIES];
    int unsigned         fill_ptr;
    logic [CNT_BITS-1:0] misses;
    logic [CAP_BITS-1:0] capacity_reg;
    fcmc_result_t        pending_results [$];
    int unsigned         mismatches;

    function new();
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_key[i]   = '0;
      end
      fill_ptr     = 0;
      misses       = '0;
      capacity_reg = CAP_RESET;
      mismatches   = 0;
    endfunction

    // zero acts as one, anything past the store size is clipped
    function int unsigned active_slots();
      int unsigned c;
      c = capacity_reg;
      if (c == 0) c = 1;
      if (c > MAX_ENTRIES) c = MAX_ENTRIES;
      return c;
    endfunction

    function void set_capacity(logic [CAP_BITS-1:0] value);
      capacity_reg = value;
    endfunction

    function void note_lookup(logic [KEY_BITS-1:0] key);
      int unsigned  span;
      bit           found;
      fcmc_result_t res;
      span  = active_slots();
      found = 1'b0;
      for (int i = 0; i < span; i++)
        if (slot_valid[i] && slot_key[i] == key) found = 1'b1;
      if (!found) begin
        // pointer left past a lowered capacity wraps before the insert
        if (fill_ptr >= span) fill_ptr = 0;
        slot_key[fill_ptr]   = key;
        slot_valid[fill_ptr] = 1'b1;
        fill_ptr++;
        if (fill_ptr >= span) fill_ptr = 0;
        if (misses != '1) misses++;
      end
      res.hit        = found;
      res.miss_total = misses;
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [OUT_DATA_BITS-1:0] beat);
      fcmc_result_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with no lookup pending: %h", beat);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (beat[0] !== want.hit) begin
        $error("hit: expected %0d, actual %0d", want.hit, beat[0]);
        mismatches++;
      end
      if (beat[32:1] !== want.miss_total) begin
        $error("miss_total: expected %0d, actual %0d", want.miss_total, beat[32:1]);
        mismatches++;
      end
      if (beat[OUT_DATA_BITS-1:33] !== '0) begin
        $error("pad: expected 0, actual %h", beat[OUT_DATA_BITS-1:33]);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CAP_BITS-1:0]      cfg_data;

  lookup_board         board = new();
  logic [KEY_BITS-1:0] key_list [$];

  fifo_cache_miss_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [15:0] key
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [0] hit, [32:1] miss_total
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)     // [7:0] capacity
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sample every handshake at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.set_capacity(cfg_data);
      if (in_tvalid && in_tready) board.note_lookup(in_tdata[KEY_BITS-1:0]);
      if (out_tvalid && out_tready) board.check_result(out_tdata);
    end
  end

  // Give up after too many cycles without any beat
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Result side backpressure: mode is redrawn at random from four patterns
  initial begin : result_sink
    int          mode;
    int unsigned tick;
    out_tready = 1'b0;
    mode       = 0;
    tick       = 0;
    forever begin
      @(negedge clk);
      if (tick % 50 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        2: out_tready <= ($urandom_range(0, 7) == 0);
        default: out_tready <= (tick % 5 != 0);
      endcase
      tick++;
    end
  end

  // Present one key and hold it until taken; returns at a falling edge
  task automatic send_key(input logic [KEY_BITS-1:0] key);
    in_tdata  <= key;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic run_list();
    foreach (key_list[i]) send_key(key_list[i]);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (board.outstanding() != 0) @(negedge clk);
  endtask

  // Capacity changes only with nothing in flight
  task automatic retune(input logic [CAP_BITS-1:0] value);
    wait_drained();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly keys from a small window so hits happen, sometimes any key
  function automatic logic [KEY_BITS-1:0] pick_key(logic [KEY_BITS-1:0] base,
                                                   int unsigned pool);
    if ($urandom_range(0, 4) == 0) return KEY_BITS'($urandom);
    return base + KEY_BITS'($urandom_range(0, pool - 1));
  endfunction

  initial begin : stimulus
    int                  sent;
    int                  phase;
    int                  phase_len;
    int                  burst;
    int                  gap;
    int unsigned         eff;
    int unsigned         pool;
    bit                  paused_once;
    bit                  pause_now;
    logic [CAP_BITS-1:0] cap;
    logic [KEY_BITS-1:0] base;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    sent        = 0;
    phase       = 0;
    paused_once = 1'b0;
    base        = KEY_BITS'($urandom);
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Key extremes, hits on both, then alternating bit patterns
    key_list = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};
    run_list();
    // Capacity below the pointer, then wrap and overwrite
    retune(8'd4);
    key_list = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd1};
    run_list();
    // Zero capacity behaves as one slot
    retune(8'd0);
    key_list = '{16'd7, 16'd7, 16'd8};
    run_list();
    // Slots above the capacity are hidden, then seen again
    retune(8'd6);
    key_list = '{16'd100, 16'd101, 16'd102, 16'd103, 16'd104, 16'd105};
    run_list();
    retune(8'd2);
    key_list = '{16'd104};
    run_list();
    retune(8'd6);
    key_list = '{16'd105};
    run_list();
    // Oversized capacity clips to the store size
    retune(8'd255);
    key_list = '{16'hFFFF};
    run_list();

    // Random phases, each with its own capacity
    while (sent < RANDOM_ITEMS) begin
      case (phase % 8)
        0: cap = 8'd1;
        1: cap = 8'd128;
        2: cap = 8'd0;
        3: cap = 8'd255;
        4: cap = CAP_BITS'($urandom_range(2, 16));
        5: cap = CAP_BITS'($urandom_range(17, 128));
        6: cap = CAP_BITS'($urandom_range(129, 255));
        default: cap = CAP_BITS'($urandom_range(1, 8));
      endcase
      retune(cap);
      eff = (cap == 0) ? 1 : ((cap > MAX_ENTRIES) ? MAX_ENTRIES : cap);
      pool = eff + eff / 2 + 1;
      if ($urandom_range(0, 1) == 0) base = KEY_BITS'($urandom);
      phase_len = $urandom_range(30, 70);
      while (phase_len > 0 && sent < RANDOM_ITEMS) begin
        burst = $urandom_range(1, 12);
        if (burst > phase_len) burst = phase_len;
        repeat (burst) begin
          send_key(pick_key(base, pool));
          sent++;
          phase_len--;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        pause_now = !paused_once && phase == 2 && phase_len < 20;
        if (gap > 0 || pause_now) begin
          in_tvalid <= 1'b0;
          // hold off once until every lookup has come back
          if (pause_now) begin
            wait_drained();
            paused_once = 1'b1;
          end
          repeat (gap) @(negedge clk);
        end
      end
      in_tvalid <= 1'b0;
      phase++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (board.outstanding() != 0) begin
      $error("%0d lookups never answered", board.outstanding());
      board.mismatches++;
    end
    if (board.mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/fcmc_pkg.sv
rtl/fcmc_front.sv
rtl/fcmc_back.sv
rtl/fifo_cache_miss_counter.sv
dv/tb_top.sv
